>>> hw/rtl/permutation_mutation_engine_core_defines.svh
// Assertion macros used by the permutation mutation engine core.
`ifndef PERMUTATION_MUTATION_ENGINE_CORE_DEFINES_SVH
`define PERMUTATION_MUTATION_ENGINE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PME_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define PME_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PME_ASSERT_SAME(label, ante, cons, msg)
`define PME_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> hw/rtl/pme_pkg.sv
// Types and constants of the permutation mutation engine.
`default_nettype none
package pme_pkg;

   localparam int MAX_CITIES = 256;
   localparam int POS_W = 8;
   localparam int CNT_W = 9;
   localparam int OP_W = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_REVERSE = 2'd1;
   localparam logic [OP_W-1:0] OP_TRANSFER = 2'd2;
   localparam logic [OP_W-1:0] OP_READ = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_CITY_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_MOVE = 1'd1;

   localparam logic [CNT_W-1:0] CITY_COUNT_RESET = 9'd256;
   localparam logic [CNT_W-1:0] MAX_MOVE_RESET = 9'd10;

   typedef struct packed {
      logic             we;
      logic [POS_W-1:0] waddr;
      logic [POS_W-1:0] wdata;
      logic [POS_W-1:0] raddr;
   } tour_req_type;

endpackage
`default_nettype wire

>>> hw/rtl/permutation_mutation_engine_core.sv
// Top level of the permutation mutation engine: sequencer, address unit and registers.
//
// The block holds a permutation of up to 256 city indices, identity after reset, and
// applies one operation per request transaction: write an entry, read an entry,
// reverse a cyclic segment or move a segment past the entries that follow it.
// Every request transaction yields exactly one response transaction with a read value
// and a status bit (1 when an operand is out of range and nothing changed).
// A request is taken only while the sequencer is idle, so one item is in work at a time.
// A reversal swaps pairs from both ends of the segment inward; each swapped pair
// needs two reads and two writes to the tour store, made one after another.
// A transfer over a window of W entries runs in two passes: one pass copies
// the rotated window into scratch memory, one pass writes it back.
// The response register lets the next request be accepted while a response waits;
// when the receiver stalls, a finished item holds in the sequencer until the slot frees.
// Reset is synchronous; it restores the identity tour at once through valid bits,
// sets city_count to 256 and max_move_length to 10, and needs no clearing pass.
// Configuration writes must be made while the block is idle.
`default_nettype none
`include "permutation_mutation_engine_core_defines.svh"
module permutation_mutation_engine_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [pme_pkg::OP_W-1:0]      req_operation,
   input  wire logic [pme_pkg::POS_W-1:0]     req_start_pos,
   input  wire logic [pme_pkg::POS_W-1:0]     req_end_pos,
   input  wire logic [pme_pkg::POS_W-1:0]     req_move_length,
   input  wire logic [pme_pkg::POS_W-1:0]     req_hop_length,
   input  wire logic [pme_pkg::POS_W-1:0]     req_write_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [pme_pkg::POS_W-1:0]     rsp_read_value,
   output logic                               rsp_status,
   input  wire logic                          csr_write_enable,
   input  wire logic [pme_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pme_pkg::CNT_W-1:0]     csr_write_data
);
   import pme_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD_WAIT = 4'd1;
   localparam logic [3:0] S_RV_RDA = 4'd2;
   localparam logic [3:0] S_RV_RDB = 4'd3;
   localparam logic [3:0] S_RV_WRA = 4'd4;
   localparam logic [3:0] S_RV_WRB = 4'd5;
   localparam logic [3:0] S_TR_P1 = 4'd6;
   localparam logic [3:0] S_TR_P2 = 4'd7;
   localparam logic [3:0] S_FINISH = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] city_count_ff, max_move_ff;
   logic [POS_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [POS_W-1:0] pa_ff, pa_in, pb_ff, pb_in, hold_ff, hold_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, w_ff, w_in;
   logic [POS_W-1:0] src_ff, src_in;
   logic             p_valid_ff, p_valid_in;
   logic [POS_W-1:0] p_idx_ff, p_idx_in;
   logic [POS_W-1:0] res_value_ff, res_value_in;
   logic             res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_status_ff, rsp_status_in;

   logic             accept;
   logic             base_ok, end_ok, move_ok;
   logic [POS_W-1:0] move_eff;
   logic [CNT_W-1:0] ep_inc, ep_adj, k_init;
   logic [CNT_W-1:0] wrap_sum;
   logic [POS_W-1:0] wrap_pos;
   logic             rsp_free;

   tour_req_type     tour_req;
   logic [POS_W-1:0] tour_rdata;
   logic             scr_we;
   logic [POS_W-1:0] scr_rdata;

   pme_tour u_tour (
      .clock(clock),
      .reset(reset),
      .req(tour_req),
      .rdata(tour_rdata)
   );

   pme_ram #(
      .WIDTH(POS_W),
      .DEPTH(MAX_CITIES)
   ) u_scratch (
      .clock(clock),
      .we(scr_we),
      .waddr(p_idx_ff),
      .wdata(tour_rdata),
      .raddr(cnt_ff[POS_W-1:0]),
      .rdata(scr_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   assign base_ok = (city_count_ff >= CNT_W'(2)) && (city_count_ff <= CNT_W'(MAX_CITIES))
                    && ({1'b0, req_start_pos} < city_count_ff);
   assign end_ok = ({1'b0, req_end_pos} < city_count_ff);
   assign move_eff = (req_move_length == '0) ? POS_W'(1) : req_move_length;
   assign move_ok = ({1'b0, req_move_length} < max_move_ff)
                    && ({1'b0, move_eff} < city_count_ff)
                    && (req_hop_length != '0)
                    && ({1'b0, req_hop_length} <= (city_count_ff - {1'b0, move_eff}));

   assign ep_inc = {1'b0, req_end_pos} + CNT_W'(1);
   assign ep_adj = (req_start_pos == req_end_pos)
                   ? ((ep_inc == city_count_ff) ? '0 : ep_inc)
                   : {1'b0, req_end_pos};
   assign k_init = ({1'b0, req_start_pos} > ep_adj) ? (ep_adj + city_count_ff) : ep_adj;

   always_comb begin
      case (state_ff)
         S_RV_RDA: wrap_sum = a_ff;
         S_RV_RDB: wrap_sum = b_ff;
         S_TR_P1:  wrap_sum = {1'b0, j_ff} + {1'b0, src_ff};
         S_TR_P2:  wrap_sum = {1'b0, j_ff} + {1'b0, p_idx_ff};
         default:  wrap_sum = '0;
      endcase
      if (wrap_sum >= city_count_ff) begin
         wrap_pos = POS_W'(wrap_sum - city_count_ff);
      end else begin
         wrap_pos = wrap_sum[POS_W-1:0];
      end
   end

   always_comb begin
      tour_req = '0;
      case (state_ff)
         S_IDLE: begin
            tour_req.raddr = req_start_pos;
            if (accept && base_ok && (req_operation == OP_WRITE)) begin
               tour_req.we = 1'b1;
               tour_req.waddr = req_start_pos;
               tour_req.wdata = req_write_value;
            end
         end
         S_RV_RDA, S_RV_RDB, S_TR_P1: begin
            tour_req.raddr = wrap_pos;
         end
         S_RV_WRA: begin
            tour_req.we = 1'b1;
            tour_req.waddr = pa_ff;
            tour_req.wdata = tour_rdata;
         end
         S_RV_WRB: begin
            tour_req.we = 1'b1;
            tour_req.waddr = pb_ff;
            tour_req.wdata = hold_ff;
         end
         S_TR_P2: begin
            tour_req.we = p_valid_ff;
            tour_req.waddr = wrap_pos;
            tour_req.wdata = scr_rdata;
         end
         default: begin
            tour_req = '0;
         end
      endcase
   end

   assign scr_we = (state_ff == S_TR_P1) && p_valid_ff;

   always_comb begin
      state_in = state_ff;
      j_in = j_ff;
      a_in = a_ff;
      b_in = b_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      hold_in = hold_ff;
      cnt_in = cnt_ff;
      w_in = w_ff;
      src_in = src_ff;
      p_valid_in = p_valid_ff;
      p_idx_in = p_idx_ff;
      res_value_in = res_value_ff;
      res_status_in = res_status_ff;
      rsp_value_in = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               j_in = req_start_pos;
               res_value_in = '0;
               res_status_in = 1'b1;
               state_in = S_FINISH;
               if (base_ok) begin
                  case (req_operation)
                     OP_WRITE: begin
                        res_status_in = 1'b0;
                     end
                     OP_READ: begin
                        state_in = S_RD_WAIT;
                     end
                     OP_REVERSE: begin
                        if (end_ok) begin
                           a_in = {1'b0, req_start_pos};
                           b_in = k_init;
                           state_in = S_RV_RDA;
                        end
                     end
                     default: begin
                        if (move_ok) begin
                           cnt_in = '0;
                           src_in = move_eff;
                           w_in = {1'b0, move_eff} + {1'b0, req_hop_length};
                           p_valid_in = 1'b0;
                           state_in = S_TR_P1;
                        end
                     end
                  endcase
               end
            end
         end
         S_RD_WAIT: begin
            res_value_in = tour_rdata;
            res_status_in = 1'b0;
            state_in = S_FINISH;
         end
         S_RV_RDA: begin
            if (a_ff < b_ff) begin
               pa_in = wrap_pos;
               state_in = S_RV_RDB;
            end else begin
               res_status_in = 1'b0;
               state_in = S_FINISH;
            end
         end
         S_RV_RDB: begin
            pb_in = wrap_pos;
            hold_in = tour_rdata;
            state_in = S_RV_WRA;
         end
         S_RV_WRA: begin
            state_in = S_RV_WRB;
         end
         S_RV_WRB: begin
            a_in = a_ff + CNT_W'(1);
            b_in = b_ff - CNT_W'(1);
            state_in = S_RV_RDA;
         end
         S_TR_P1: begin
            if (cnt_ff < w_ff) begin
               cnt_in = cnt_ff + CNT_W'(1);
               src_in = (({1'b0, src_ff} + CNT_W'(1)) == w_ff) ? '0 : src_ff + POS_W'(1);
               p_valid_in = 1'b1;
               p_idx_in = cnt_ff[POS_W-1:0];
            end else begin
               cnt_in = '0;
               p_valid_in = 1'b0;
               state_in = S_TR_P2;
            end
         end
         S_TR_P2: begin
            if (cnt_ff < w_ff) begin
               cnt_in = cnt_ff + CNT_W'(1);
               p_valid_in = 1'b1;
               p_idx_in = cnt_ff[POS_W-1:0];
            end else begin
               p_valid_in = 1'b0;
               res_status_in = 1'b0;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         city_count_ff <= CITY_COUNT_RESET;
         max_move_ff <= MAX_MOVE_RESET;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         p_valid_ff <= p_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               REG_CITY_COUNT: city_count_ff <= csr_write_data;
               REG_MAX_MOVE:   max_move_ff <= csr_write_data;
               default:        city_count_ff <= city_count_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in;
      a_ff <= a_in;
      b_ff <= b_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      hold_ff <= hold_in;
      cnt_ff <= cnt_in;
      w_ff <= w_in;
      src_ff <= src_in;
      p_idx_ff <= p_idx_in;
      res_value_ff <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

   `PME_ASSERT_NEXT(a_busy_after_accept, accept, state_ff != S_IDLE,
      "sequencer stayed idle after accepting a transaction")
   `PME_ASSERT_SAME(a_swap_order, (state_ff == S_RV_RDB) || (state_ff == S_RV_WRA)
      || (state_ff == S_RV_WRB), a_ff < b_ff, "reversal swap with crossed pointers")
   `PME_ASSERT_SAME(a_copy_bound, (state_ff == S_TR_P1) || (state_ff == S_TR_P2),
      cnt_ff <= w_ff, "transfer counter ran past the window")
   `PME_ASSERT_SAME(a_fail_value, rsp_valid_ff && rsp_status_ff, rsp_value_ff == '0,
      "failed transaction returned a nonzero read value")
   `PME_ASSERT_NEXT(a_finish_loads, (state_ff == S_FINISH) && !rsp_valid_ff,
      rsp_valid_ff, "finished item did not reach a free response register")

endmodule
`default_nettype wire

>>> hw/rtl/pme_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> hw/rtl/pme_tour.sv
// Tour store: RAM plus per-entry valid bits so that unwritten entries read as their index.
`default_nettype none
module pme_tour (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pme_pkg::tour_req_type     req,
   output logic      [pme_pkg::POS_W-1:0] rdata
);
   import pme_pkg::*;

   logic [MAX_CITIES-1:0] valid_ff;
   logic                  rvalid_ff;
   logic [POS_W-1:0]      raddr_ff;
   logic [POS_W-1:0]      ram_rdata;

   pme_ram #(
      .WIDTH(POS_W),
      .DEPTH(MAX_CITIES)
   ) u_ram (
      .clock(clock),
      .we(req.we),
      .waddr(req.waddr),
      .wdata(req.wdata),
      .raddr(req.raddr),
      .rdata(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.we) begin
         valid_ff[req.waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rvalid_ff <= valid_ff[req.raddr];
      raddr_ff <= req.raddr;
   end

   assign rdata = rvalid_ff ? ram_rdata : raddr_ff;

endmodule
`default_nettype wire
